FILE: src/shamh_pkg.sv
// ----------------------------------------------------------------------------
// shamh_pkg: SHA-256 message hash shared definitions
// Round constants, initial hash, round/schedule functions and FSM type.
// ----------------------------------------------------------------------------
package shamh_pkg;

  localparam int WORD_W   = 32;
  localparam int BLK_DEPTH = 16;
  localparam int POS_W    = 4;
  localparam int ROUNDS_W = 6;
  localparam int LEN_W    = 64;
  localparam int CNT_W    = 3;
  localparam int DIG_WORDS = 8;

  localparam logic [CNT_W-1:0]    FULL_BYTES = 3'd4;
  localparam logic [WORD_W-1:0]   PAD_WORD   = 32'h8000_0000;
  localparam logic [POS_W-1:0]    POS_LEN_HI = 4'd14;
  localparam logic [POS_W-1:0]    POS_LAST   = 4'd15;
  localparam logic [4:0]          LOAD_LAST  = 5'd16;
  localparam logic [ROUNDS_W-1:0] ROUND_LAST = 6'd63;
  localparam logic [3:0]          DIG_COUNT  = 4'd8;

  localparam logic [WORD_W-1:0] HASH_IV [DIG_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: src/sha256_message_hash_top.sv
// ----------------------------------------------------------------------------
// sha256_message_hash_top: SHA-256 hash of a word-streamed message
// Buffers 16-word blocks in a RAM, compresses them one round per cycle,
// pads the tail and streams out the 8 digest words.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                | tuser              | tlast
//  --------+-----+----------------------+--------------------+-------------
//  in_     | in  | [31:0] message_word  | [2:0] valid_bytes  | final_word
//  out_    | out | [31:0] digest_word   | -                  | digest_last
//
// Flow: a non-final word is written into the RAM, except that the 16th word of a
//   block also starts compression (RAM read-out into the schedule window, 64
//   rounds, one chain add). A final word is followed by the pad, zero-fill and
//   length words, one compression per tail block, and the load of the digest
//   buffer.
// Reset: rst_n synchronous, active low; chain value returns to the initial hash.
// Stalls: the digest sits in its own output buffer, so a new message is taken
//   while it drains; a second digest waits until the buffer is empty.
// ----------------------------------------------------------------------------
module sha256_message_hash_top
  import shamh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] message_word
  input  logic [2:0]  in_tuser,   // [2:0] valid_bytes
  input  logic        in_tlast,   // final_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);

  state_t state_r, state_nxt;

  logic [POS_W-1:0]    pos_r;      // next free slot in the block RAM
  logic [LEN_W-1:0]    bytes_r;    // message byte count, wraps
  logic                fin_r;      // final word seen, tail in progress
  logic                pad80_r;    // pad word still owed (full final word)
  logic                len_r;      // high length word already written
  logic [4:0]          ld_cnt_r;
  logic [ROUNDS_W-1:0] rnd_r;
  logic [3:0]          dig_cnt_r;

  logic [WORD_W-1:0] chain_r [DIG_WORDS];
  logic [WORD_W-1:0] wv_r    [DIG_WORDS]; // working variables a..h
  logic [WORD_W-1:0] win_r   [BLK_DEPTH]; // schedule window, w[t] at 0
  logic [WORD_W-1:0] dig_r   [DIG_WORDS]; // output buffer
  logic [WORD_W-1:0] blk_mem [BLK_DEPTH];
  logic [WORD_W-1:0] rd_q;

  logic              in_acc, out_acc;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] tail_word;
  logic              push_en;
  logic [WORD_W-1:0] push_data;
  logic [WORD_W-1:0] t1, t2, w_new;
  logic              dig_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (dig_cnt_r != 4'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = dig_r[0];
  assign out_tlast  = (dig_cnt_r == 4'd1);
  assign dig_load   = (state_r == ST_DONE) && (dig_cnt_r == 4'd0);

  // counts above four mean a full word
  assign cnt = (in_tuser > FULL_BYTES) ? FULL_BYTES : in_tuser;

  // short final word: keep leading bytes, pad byte in the first free one
  always_comb begin
    case (cnt)
      3'd0:    tail_word = PAD_WORD;
      3'd1:    tail_word = (in_tdata & 32'hff00_0000) | 32'h0080_0000;
      3'd2:    tail_word = (in_tdata & 32'hffff_0000) | 32'h0000_8000;
      3'd3:    tail_word = (in_tdata & 32'hffff_ff00) | 32'h0000_0080;
      default: tail_word = in_tdata;
    endcase
  end

  // one block RAM write per cycle: input word, tail word, or pad, fill or length word
  always_comb begin
    push_en   = 1'b0;
    push_data = '0;
    case (state_r)
      ST_IDLE: begin
        push_en   = in_acc;
        push_data = in_tlast ? tail_word : in_tdata;
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad80_r) begin
          push_data = PAD_WORD;
        end else if (pos_r == POS_LEN_HI) begin
          push_data = bytes_r[60:29];
        end else if (pos_r == POS_LAST && len_r) begin
          push_data = {bytes_r[28:0], 3'b000};
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (pos_r == POS_LAST) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pos_r == POS_LAST) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (ld_cnt_r == LOAD_LAST) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_DONE: begin
        if (dig_cnt_r == 4'd0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // round datapath
  assign t1 = wv_r[7] + big_sig1(wv_r[4]) + choose(wv_r[4], wv_r[5], wv_r[6])
            + ROUND_K[rnd_r] + win_r[0];
  assign t2 = big_sig0(wv_r[0]) + major(wv_r[0], wv_r[1], wv_r[2]);
  assign w_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];

  // block RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_en) begin
      blk_mem[pos_r] <= push_data;
    end
    rd_q <= blk_mem[ld_cnt_r[POS_W-1:0]];
  end

  // schedule window and output buffer
  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD && ld_cnt_r != 5'd0) || state_r == ST_ROUND) begin
      for (int i = 0; i < BLK_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLK_DEPTH-1] <= (state_r == ST_LOAD) ? rd_q : w_new;
    end
    if (dig_load) begin
      for (int i = 0; i < DIG_WORDS; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < DIG_WORDS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      bytes_r   <= '0;
      fin_r     <= 1'b0;
      pad80_r   <= 1'b0;
      len_r     <= 1'b0;
      ld_cnt_r  <= '0;
      rnd_r     <= '0;
      dig_cnt_r <= '0;
      for (int i = 0; i < DIG_WORDS; i++) begin
        chain_r[i] <= HASH_IV[i];
      end
    end else begin
      state_r <= state_nxt;
      if (push_en) begin
        pos_r <= pos_r + 4'd1;
      end
      if (out_acc) begin
        dig_cnt_r <= dig_cnt_r - 4'd1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            bytes_r <= bytes_r + (in_tlast ? LEN_W'(cnt) : LEN_W'(FULL_BYTES));
            if (in_tlast) begin
              fin_r   <= 1'b1;
              pad80_r <= (cnt == FULL_BYTES);
            end
          end
        end
        ST_PAD: begin
          if (pad80_r) begin
            pad80_r <= 1'b0;
          end else if (pos_r == POS_LEN_HI) begin
            len_r <= 1'b1;
          end
        end
        ST_LOAD: begin
          if (ld_cnt_r == LOAD_LAST) begin
            ld_cnt_r <= '0;
            rnd_r    <= '0;
            for (int i = 0; i < DIG_WORDS; i++) begin
              wv_r[i] <= chain_r[i];
            end
          end else begin
            ld_cnt_r <= ld_cnt_r + 5'd1;
          end
        end
        ST_ROUND: begin
          rnd_r   <= rnd_r + 6'd1;
          wv_r[0] <= t1 + t2;
          wv_r[1] <= wv_r[0];
          wv_r[2] <= wv_r[1];
          wv_r[3] <= wv_r[2];
          wv_r[4] <= wv_r[3] + t1;
          wv_r[5] <= wv_r[4];
          wv_r[6] <= wv_r[5];
          wv_r[7] <= wv_r[6];
        end
        ST_ADD: begin
          for (int i = 0; i < DIG_WORDS; i++) begin
            chain_r[i] <= chain_r[i] + wv_r[i];
          end
        end
        ST_DONE: begin
          if (dig_load) begin
            dig_cnt_r <= DIG_COUNT;
            bytes_r   <= '0;
            fin_r     <= 1'b0;
            len_r     <= 1'b0;
            pos_r     <= '0;
            for (int i = 0; i < DIG_WORDS; i++) begin
              chain_r[i] <= HASH_IV[i];
            end
          end
        end
        default: begin
          fin_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: src/shamh_checker.sv
// ----------------------------------------------------------------------------
// shamh_checker: port-level checks for the SHA-256 message hash
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module shamh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // stalled digest item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest item changed under stall");

  // no input is taken right after a final word
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after final word");

  // digest burst ends cleanly after its last word
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("digest continued past last word");

  // a non-final word never starts a digest
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> !$rose(out_tvalid))
    else $error("digest started without final word");

endmodule

bind sha256_message_hash_top shamh_checker u_shamh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
